FILE: design/pid_integral_separation_core_assert.svh
// Assertion macros shared by the PID core.
`ifndef PID_INTEGRAL_SEPARATION_CORE_ASSERT_SVH
`define PID_INTEGRAL_SEPARATION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIS_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pis_pkg.sv
package pis_pkg;

  localparam int unsigned IdxWidth = 8;
  localparam int unsigned CfgWidth = 16;

  localparam logic [IdxWidth-1:0] REG_GAIN_P           = 8'd0;
  localparam logic [IdxWidth-1:0] REG_GAIN_I           = 8'd1;
  localparam logic [IdxWidth-1:0] REG_GAIN_D           = 8'd2;
  localparam logic [IdxWidth-1:0] REG_DRIVE_OFFSET     = 8'd3;
  localparam logic [IdxWidth-1:0] REG_DRIVE_MAX        = 8'd4;
  localparam logic [IdxWidth-1:0] REG_DRIVE_MIN        = 8'd5;
  localparam logic [IdxWidth-1:0] REG_SEPARATION_LIMIT = 8'd6;
  localparam logic [IdxWidth-1:0] REG_STOP_BAND        = 8'd7;

  localparam logic signed [15:0] DriveMaxReset        = 16'sh7FFF;
  localparam logic signed [15:0] DriveMinReset        = 16'sh8000;
  localparam logic        [14:0] SeparationLimitReset = 15'd2560;
  localparam logic        [14:0] StopBandReset        = 15'd128;

  localparam logic signed [31:0] SumMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SumMin = 32'sh8000_0000;

endpackage

FILE: design/pid_integral_separation_core.sv
// Positional PID controller with integral separation. Each input word carries a
// target and a measured sample in signed Q8.8; each output word carries one
// clamped signed integer drive value. The block takes one word per cycle unless
// the output stalls, and gives the matching drive through the input, product,
// sum and output registers; the error integral is updated in the cycle a word is
// accepted, so that single saturating add sets the one-word-per-cycle rate. The
// user must write gains, offset, limits, separation threshold and stop band over
// the configuration channel only while no word is in flight; it is not enforced.
module pid_integral_separation_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [31:0]                       s_tdata,   // target[15:0], measured[31:16]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,   // drive[15:0]
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pis_pkg::IdxWidth-1:0]      cfg_index,
  input  logic [pis_pkg::CfgWidth-1:0]      cfg_data
);

  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic        [14:0] drive_offset;
  logic signed [15:0] drive_max;
  logic signed [15:0] drive_min;
  logic        [14:0] separation_limit;
  logic        [14:0] stop_band;

  logic signed [15:0] prev_measured;
  logic signed [31:0] error_sum;
  logic signed [31:0] error_sum_next;

  logic a_valid, b_valid, c_valid, d_valid;
  logic a_ready, b_ready, c_ready, d_ready;
  logic accept;

  logic signed [16:0] a_error;
  logic signed [16:0] a_delta;
  logic signed [31:0] a_esum;

  logic signed [32:0] b_p;
  logic signed [47:0] b_i;
  logic signed [32:0] b_d;

  logic signed [32:0] c_base;
  logic               c_pos;
  logic               c_neg;

  logic signed [15:0] d_drive;

  logic signed [15:0] target_in;
  logic signed [15:0] measured_in;
  logic signed [16:0] error_in;
  logic signed [16:0] delta_in;
  logic        [16:0] error_abs;
  logic        [16:0] measured_abs;
  logic signed [32:0] acc;
  logic signed [48:0] sum;
  logic signed [33:0] adj;
  logic signed [33:0] offset_ext;
  logic signed [33:0] clamped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      drive_offset     <= '0;
      drive_max        <= pis_pkg::DriveMaxReset;
      drive_min        <= pis_pkg::DriveMinReset;
      separation_limit <= pis_pkg::SeparationLimitReset;
      stop_band        <= pis_pkg::StopBandReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pis_pkg::REG_GAIN_P:           gain_p           <= cfg_data;
        pis_pkg::REG_GAIN_I:           gain_i           <= cfg_data;
        pis_pkg::REG_GAIN_D:           gain_d           <= cfg_data;
        pis_pkg::REG_DRIVE_OFFSET:     drive_offset     <= cfg_data[14:0];
        pis_pkg::REG_DRIVE_MAX:        drive_max        <= cfg_data;
        pis_pkg::REG_DRIVE_MIN:        drive_min        <= cfg_data;
        pis_pkg::REG_SEPARATION_LIMIT: separation_limit <= cfg_data[14:0];
        pis_pkg::REG_STOP_BAND:        stop_band        <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign d_ready  = !d_valid || m_tready;
  assign c_ready  = !c_valid || d_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    target_in    = $signed(s_tdata[15:0]);
    measured_in  = $signed(s_tdata[31:16]);
    error_in     = 17'(target_in) - 17'(measured_in);
    delta_in     = 17'(measured_in) - 17'(prev_measured);
    error_abs    = error_in[16] ? 17'(-error_in) : error_in;
    measured_abs = measured_in[15] ? 17'(-17'(measured_in)) : 17'(measured_in);
    acc          = 33'(error_sum) + 33'(error_in);
    if (gain_i == '0) begin
      error_sum_next = '0;
    end else if (target_in == '0 && measured_abs < {2'b00, stop_band}) begin
      error_sum_next = '0;
    end else if (error_abs > {2'b00, separation_limit}) begin
      error_sum_next = error_sum;
    end else if (acc[32] != acc[31]) begin
      error_sum_next = acc[32] ? pis_pkg::SumMin : pis_pkg::SumMax;
    end else begin
      error_sum_next = acc[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum     <= '0;
      prev_measured <= '0;
    end else if (accept) begin
      error_sum     <= error_sum_next;
      prev_measured <= measured_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= s_tvalid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_error <= error_in;
      a_delta <= delta_in;
      a_esum  <= error_sum_next;
    end
    if (b_ready && a_valid) begin
      b_p <= 33'(a_error) * 33'(gain_p);
      b_i <= 48'(a_esum) * 48'(gain_i);
      b_d <= 33'(a_delta) * 33'(gain_d);
    end
    if (c_ready && b_valid) begin
      c_base <= sum[48:16];
      c_pos  <= !sum[48] && (sum != '0);
      c_neg  <= sum[48];
    end
    if (d_ready && c_valid) begin
      d_drive <= clamped[15:0];
    end
  end

  always_comb begin
    sum        = 49'(b_i) + 49'(b_p) - 49'(b_d);
    offset_ext = $signed({19'b0, drive_offset});
    if (c_pos) begin
      adj = 34'(c_base) + offset_ext;
    end else if (c_neg) begin
      adj = 34'(c_base) - offset_ext;
    end else begin
      adj = 34'(c_base);
    end
    clamped = adj;
    if (clamped > 34'(drive_max)) clamped = 34'(drive_max);
    if (clamped < 34'(drive_min)) clamped = 34'(drive_min);
  end

  assign m_tvalid = d_valid;
  assign m_tdata  = d_drive;

`include "pid_integral_separation_core_assert.svh"

  `PIS_ASSERT_NEXT(a_integral_clear, clk, rst, accept && gain_i == '0, error_sum == '0, "integral not cleared with zero gain_i")
  `PIS_ASSERT_NEXT(a_integral_hold, clk, rst, !accept, $stable(error_sum) && $stable(prev_measured), "state changed without an accepted word")
  `PIS_ASSERT_NEXT(a_sum_stall, clk, rst, c_valid && !d_ready, c_valid && $stable(c_base), "sum stage lost a word while stalled")
  `PIS_ASSERT_SAME(a_ready_empty, clk, rst, !a_valid, s_tready, "input not ready with empty input stage")

endmodule
